// ===== sv/qslerp_pkg.sv =====
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared constants, register codes and angle table helpers for the slerp block.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF    = 18;

    localparam int CFG_REGS = 8;
    localparam int ADDR_W   = $clog2(CFG_REGS) + 2;
    localparam int DATA_W   = 32;

    localparam int Q_W     = 16;
    localparam int BLEND_W = 18;
    localparam int MC_W    = 31;
    localparam int S_W     = 31;
    localparam int CD_W    = 34;
    localparam int DIV_QW  = 42;
    localparam int FRAC_Q30 = 30;

    localparam int          DEGEN_LIMIT = 1048576;
    localparam int          ONE_Q30     = 1073741824;
    localparam int          BLEND_ONE   = 65536;
    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [31:0] GAIN_Q30    = 32'h26DD3B6A;

    typedef enum logic [ADDR_W-3:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_START_W = 3'd3,
        REG_END_X   = 3'd4,
        REG_END_Y   = 3'd5,
        REG_END_Z   = 3'd6,
        REG_END_W   = 3'd7
    } t_cfg_idx;

    function automatic logic [63:0] to_angle(input logic [63:0] q60, input int afb);
        return (q60 + (64'd1 << (59 - afb))) >> (60 - afb);
    endfunction

    // atan(2^-i) in Q.60: pi/4 for i == 0, else the truncated odd power series
    function automatic logic [63:0] atan_q60(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          k;
        acc = '0;
        if (i == 0) begin
            acc = PI_Q60 >> 2;
        end else begin
            for (k = 0; i * (2 * k + 1) <= 60; k++) begin
                term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
                if (k[0]) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] atan_angle(input int i, input int afb);
        return to_angle(atan_q60(i), afb);
    endfunction

endpackage

// ===== sv/qslerp_if.sv =====
// ----------------------------------------------------------------------------
// qslerp_if
// Valid/ready channels for the blend input and the interpolated output.
// ----------------------------------------------------------------------------
interface qslerp_in_if;
    import qslerp_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [BLEND_W-1:0] blend;
    modport source (output valid, output blend, input ready);
    modport sink   (input valid, input blend, output ready);
endinterface

interface qslerp_out_if;
    import qslerp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] out_x;
    logic signed [Q_W-1:0] out_y;
    logic signed [Q_W-1:0] out_z;
    logic signed [Q_W-1:0] out_w;
    logic                  degenerate;
    modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                    output degenerate, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                    input degenerate, output ready);
endinterface

// ===== sv/qslerp_cordic.sv =====
// ----------------------------------------------------------------------------
// qslerp_cordic
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module qslerp_cordic #(
    parameter bit VECTORING = 1'b0,
    parameter int STEPS     = qslerp_pkg::CORDIC_STEPS_DEF,
    parameter int AFB       = qslerp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int DW        = qslerp_pkg::CD_W,
    parameter int AW        = qslerp_pkg::ANGLE_FRAC_BITS_DEF + 4,
    parameter int TAG_W     = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic signed [AW-1:0] i_z,
    input  logic [TAG_W-1:0]     i_tag,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic signed [AW-1:0] o_z,
    output logic [TAG_W-1:0]     o_tag
);
    import qslerp_pkg::*;

    logic                 w_v   [0:STEPS];
    logic signed [DW-1:0] w_x   [0:STEPS];
    logic signed [DW-1:0] w_y   [0:STEPS];
    logic signed [AW-1:0] w_z   [0:STEPS];
    logic [TAG_W-1:0]     w_tag [0:STEPS];

    assign w_v[0]   = i_valid;
    assign w_x[0]   = i_x;
    assign w_y[0]   = i_y;
    assign w_z[0]   = i_z;
    assign w_tag[0] = i_tag;

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_stage
            localparam logic signed [AW-1:0] ST = signed'(AW'(atan_angle(i, AFB)));
            logic                 r_v;
            logic signed [DW-1:0] r_x;
            logic signed [DW-1:0] r_y;
            logic signed [AW-1:0] r_z;
            logic [TAG_W-1:0]     r_tag;
            logic                 pos;
            logic signed [DW-1:0] n_x;
            logic signed [DW-1:0] n_y;
            logic signed [AW-1:0] n_z;

            always_comb begin
                pos = VECTORING ? (w_y[i] < 0) : (w_z[i] >= 0);
                if (pos) begin
                    n_x = w_x[i] - (w_y[i] >>> i);
                    n_y = w_y[i] + (w_x[i] >>> i);
                    n_z = w_z[i] - ST;
                end else begin
                    n_x = w_x[i] + (w_y[i] >>> i);
                    n_y = w_y[i] - (w_x[i] >>> i);
                    n_z = w_z[i] + ST;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= w_v[i];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x   <= n_x;
                    r_y   <= n_y;
                    r_z   <= n_z;
                    r_tag <= w_tag[i];
                end
            end

            assign w_v[i+1]   = r_v;
            assign w_x[i+1]   = r_x;
            assign w_y[i+1]   = r_y;
            assign w_z[i+1]   = r_z;
            assign w_tag[i+1] = r_tag;
        end
    endgenerate

    assign o_valid = w_v[STEPS];
    assign o_x     = w_x[STEPS];
    assign o_y     = w_y[STEPS];
    assign o_z     = w_z[STEPS];
    assign o_tag   = w_tag[STEPS];

endmodule

// ===== sv/qslerp_div.sv =====
// ----------------------------------------------------------------------------
// qslerp_div
// Pipelined restoring divider: signed (num << FRAC) / den, truncated toward
// zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qslerp_div #(
    parameter int NW    = qslerp_pkg::CD_W,
    parameter int SW    = qslerp_pkg::S_W,
    parameter int QW    = qslerp_pkg::DIV_QW,
    parameter int FRAC  = qslerp_pkg::FRAC_Q30,
    parameter int TAG_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num,
    input  logic [SW-1:0]        i_den,
    input  logic [TAG_W-1:0]     i_tag,
    output logic                 o_valid,
    output logic signed [QW:0]   o_quo,
    output logic [TAG_W-1:0]     o_tag
);
    localparam int DVW = NW + FRAC;
    localparam int RW  = SW + 1;

    logic [NW-1:0]  n_mag;
    logic [DVW-1:0] n_dvd;

    logic             w_v   [0:QW];
    logic [RW-1:0]    w_rem [0:QW];
    logic [QW-1:0]    w_low [0:QW];
    logic [QW-1:0]    w_q   [0:QW];
    logic [SW-1:0]    w_den [0:QW];
    logic             w_neg [0:QW];
    logic [TAG_W-1:0] w_tag [0:QW];

    logic             r_v0;
    logic [RW-1:0]    r_rem0;
    logic [QW-1:0]    r_low0;
    logic [SW-1:0]    r_den0;
    logic             r_neg0;
    logic [TAG_W-1:0] r_tag0;

    logic               r_out_v;
    logic signed [QW:0] r_out_quo;
    logic [TAG_W-1:0]   r_out_tag;

    always_comb begin
        n_mag = (i_num < 0) ? NW'(-i_num) : NW'(i_num);
        n_dvd = {n_mag, {FRAC{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= RW'(n_dvd[DVW-1:QW]);
            r_low0 <= n_dvd[QW-1:0];
            r_den0 <= i_den;
            r_neg0 <= i_num < 0;
            r_tag0 <= i_tag;
        end
    end

    assign w_v[0]   = r_v0;
    assign w_rem[0] = r_rem0;
    assign w_low[0] = r_low0;
    assign w_q[0]   = '0;
    assign w_den[0] = r_den0;
    assign w_neg[0] = r_neg0;
    assign w_tag[0] = r_tag0;

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_step
            logic             r_v;
            logic [RW-1:0]    r_rem;
            logic [QW-1:0]    r_low;
            logic [QW-1:0]    r_q;
            logic [SW-1:0]    r_den;
            logic             r_neg;
            logic [TAG_W-1:0] r_tag;
            logic [RW-1:0]    trial;
            logic             ge;
            logic [RW-1:0]    n_rem;

            always_comb begin
                trial = {w_rem[k][RW-2:0], w_low[k][QW-1-k]};
                ge    = trial >= {1'b0, w_den[k]};
                n_rem = ge ? (trial - {1'b0, w_den[k]}) : trial;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= w_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_rem;
                    r_low <= w_low[k];
                    r_q   <= {w_q[k][QW-2:0], ge};
                    r_den <= w_den[k];
                    r_neg <= w_neg[k];
                    r_tag <= w_tag[k];
                end
            end

            assign w_v[k+1]   = r_v;
            assign w_rem[k+1] = r_rem;
            assign w_low[k+1] = r_low;
            assign w_q[k+1]   = r_q;
            assign w_den[k+1] = r_den;
            assign w_neg[k+1] = r_neg;
            assign w_tag[k+1] = r_tag;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= w_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_quo <= w_neg[QW] ? -signed'({1'b0, w_q[QW]}) : signed'({1'b0, w_q[QW]});
            r_out_tag <= w_tag[QW];
        end
    end

    assign o_valid = r_out_v;
    assign o_quo   = r_out_quo;
    assign o_tag   = r_out_tag;

endmodule

// ===== sv/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point quaternion slerp between two register-held unit quaternions.
//
//   channel   direction  handshake         payload
//   i_req     in         valid/ready       blend (Q2.16)
//   o_rsp     out        valid/ready       out_x/y/z/w (Q1.15), degenerate
//   apb       in         psel/penable      start_*/end_* registers
//
// One transaction per cycle sustained; the pipe contains a 31-step square root,
// a vectoring CORDIC chain, two parallel rotation CORDIC chains and two
// parallel 42-step dividers. All stages advance on one enable; when the output
// register is full and not taken, the whole pipe holds. Synchronous reset
// clears valid bits and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_slerp #(
    parameter int ANGLE_FRAC_BITS = qslerp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = qslerp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    qslerp_in_if.sink                     i_req,
    qslerp_out_if.source                  o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qslerp_pkg::ADDR_W-1:0] paddr,
    input  logic [qslerp_pkg::DATA_W-1:0] pwdata,
    output logic [qslerp_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);
    import qslerp_pkg::*;

    localparam int AFB   = ANGLE_FRAC_BITS;
    localparam int AW    = AFB + 4;
    localparam int TH_W  = AFB + 2;
    localparam int C_W   = 2 * Q_W + 2;
    localparam int N_W   = 2 * S_W;
    localparam int SQ_RW = S_W + 2;
    localparam int KW    = DIV_QW + 1;
    localparam int P_W   = Q_W + KW;
    localparam int AC_W  = P_W + 1;
    localparam int T_W   = BLEND_W - 1;

    localparam logic [TH_W-1:0]        PI_A   = TH_W'(to_angle(PI_Q60, AFB));
    localparam logic [TH_W-1:0]        HALF_A = TH_W'(to_angle(PI_Q60 >> 1, AFB));
    localparam logic signed [AW-1:0]   PI_S   = signed'(AW'(PI_A));
    localparam logic signed [C_W-1:0]  ONE_C  = C_W'(ONE_Q30);
    localparam logic signed [CD_W-1:0] GAIN_C = signed'(CD_W'(GAIN_Q30));

    typedef struct packed {
        logic                      cneg;
        logic                      lt;
        logic                      gt;
        logic signed [BLEND_W-1:0] t;
        logic [MC_W-1:0]           mc;
    } t_sq_side;

    typedef struct packed {
        logic                      cneg;
        logic                      lt;
        logic                      gt;
        logic                      dg;
        logic signed [BLEND_W-1:0] t;
        logic [S_W-1:0]            s;
    } t_vec_tag;

    typedef struct packed {
        logic           lt;
        logic           gt;
        logic [S_W-1:0] s;
    } t_rot_tag;

    typedef struct packed {
        logic lt;
        logic gt;
    } t_div_tag;

    // ---------------- configuration registers ----------------
    logic [Q_W-1:0]        r_cfg [CFG_REGS];
    logic                  cfg_wr;
    logic signed [Q_W-1:0] q1 [4];
    logic signed [Q_W-1:0] q2 [4];

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = DATA_W'(r_cfg[paddr[ADDR_W-1:2]]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < CFG_REGS; j++) begin
                r_cfg[j] <= '0;
            end
            r_cfg[REG_START_W] <= Q_W'(16'h7FFF);
            r_cfg[REG_END_W]   <= Q_W'(16'h7FFF);
        end else if (cfg_wr) begin
            r_cfg[t_cfg_idx'(paddr[ADDR_W-1:2])] <= pwdata[Q_W-1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            q1[j] = signed'(r_cfg[j]);
            q2[j] = signed'(r_cfg[4 + j]);
        end
    end

    // ---------------- flow control ----------------
    logic r_out_v;
    logic en;

    assign en          = !r_out_v || o_rsp.ready;
    assign i_req.ready = en;

    // ---------------- S1: dot product terms ----------------
    logic                      r1_v;
    logic signed [2*Q_W-1:0]   r1_prod [4];
    logic signed [BLEND_W-1:0] r1_t;
    logic                      r1_lt;
    logic                      r1_gt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r1_prod[j] <= q1[j] * q2[j];
            end
            r1_t  <= i_req.blend;
            r1_lt <= i_req.blend < 0;
            r1_gt <= i_req.blend > BLEND_W'(BLEND_ONE);
        end
    end

    // ---------------- S2: sum, clamp, magnitude ----------------
    logic signed [C_W-1:0] c_sum;
    logic signed [C_W-1:0] c_clp;
    logic signed [C_W-1:0] c_abs;
    logic                  r2_v;
    t_sq_side              r2_sd;

    always_comb begin
        c_sum = C_W'(r1_prod[0]) + C_W'(r1_prod[1]) + C_W'(r1_prod[2]) + C_W'(r1_prod[3]);
        if (c_sum > ONE_C) begin
            c_clp = ONE_C;
        end else if (c_sum < -ONE_C) begin
            c_clp = -ONE_C;
        end else begin
            c_clp = c_sum;
        end
        c_abs = (c_clp < 0) ? -c_clp : c_clp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sd.cneg <= c_clp < 0;
            r2_sd.lt   <= r1_lt;
            r2_sd.gt   <= r1_gt;
            r2_sd.t    <= r1_t;
            r2_sd.mc   <= c_abs[MC_W-1:0];
        end
    end

    // ---------------- S3: c squared ----------------
    logic           r3_v;
    logic [N_W-1:0] r3_sq;
    t_sq_side       r3_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sq <= N_W'(r2_sd.mc) * N_W'(r2_sd.mc);
            r3_sd <= r2_sd;
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic             r_sq_v    [0:S_W];
    logic [N_W-1:0]   r_sq_n    [0:S_W];
    logic [SQ_RW-1:0] r_sq_rem  [0:S_W];
    logic [S_W-1:0]   r_sq_root [0:S_W];
    t_sq_side         r_sq_sd   [0:S_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_n[0]    <= (N_W'(1) << (N_W - 2)) - r3_sq;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_sd[0]   <= r3_sd;
        end
    end

    genvar k;
    generate
        for (k = 0; k < S_W; k++) begin : g_sqrt
            localparam int B = S_W - 1 - k;
            logic [SQ_RW-1:0] rem_sh;
            logic [SQ_RW-1:0] trial;
            logic             ge;

            always_comb begin
                rem_sh = {r_sq_rem[k][SQ_RW-3:0], r_sq_n[k][2*B+1 -: 2]};
                trial  = {r_sq_root[k], 2'b01};
                ge     = rem_sh >= trial;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_v[k+1] <= 1'b0;
                end else if (en) begin
                    r_sq_v[k+1] <= r_sq_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_n[k+1]    <= r_sq_n[k];
                    r_sq_rem[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
                    r_sq_root[k+1] <= {r_sq_root[k][S_W-2:0], ge};
                    r_sq_sd[k+1]   <= r_sq_sd[k];
                end
            end
        end
    endgenerate

    // ---------------- theta by CORDIC vectoring ----------------
    t_vec_tag              vi_tag;
    t_vec_tag              vo_tag;
    logic                  vo_v;
    logic signed [AW-1:0]  vo_z;

    always_comb begin
        vi_tag.cneg = r_sq_sd[S_W].cneg;
        vi_tag.lt   = r_sq_sd[S_W].lt;
        vi_tag.gt   = r_sq_sd[S_W].gt;
        vi_tag.dg   = r_sq_root[S_W] < S_W'(DEGEN_LIMIT);
        vi_tag.t    = r_sq_sd[S_W].t;
        vi_tag.s    = r_sq_root[S_W];
    end

    qslerp_cordic #(
        .VECTORING (1'b1),
        .STEPS     (CORDIC_STEPS),
        .AFB       (AFB),
        .DW        (CD_W),
        .AW        (AW),
        .TAG_W     ($bits(t_vec_tag))
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sq_v[S_W]),
        .i_x     (signed'(CD_W'(r_sq_sd[S_W].mc))),
        .i_y     (signed'(CD_W'(r_sq_root[S_W]))),
        .i_z     ('0),
        .i_tag   (vi_tag),
        .o_valid (vo_v),
        .o_x     (),
        .o_y     (),
        .o_z     (vo_z),
        .o_tag   (vo_tag)
    );

    // ---------------- S6: theta fold and clamp ----------------
    logic signed [AW-1:0] th_raw;
    logic [TH_W-1:0]      th_clp;
    logic                 r6_v;
    logic [TH_W-1:0]      r6_theta;
    t_vec_tag             r6_tag;

    always_comb begin
        th_raw = vo_tag.cneg ? (PI_S - vo_z) : vo_z;
        if (th_raw < 0) begin
            th_clp = '0;
        end else if (th_raw > PI_S) begin
            th_clp = PI_A;
        end else begin
            th_clp = th_raw[TH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= vo_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_theta <= th_clp;
            r6_tag   <= vo_tag;
        end
    end

    // ---------------- S7: a2 = round(theta * t) ----------------
    logic [TH_W+T_W-1:0] a2_prod;
    logic                r7_v;
    logic [TH_W-1:0]     r7_theta;
    logic [TH_W-1:0]     r7_a2;
    t_vec_tag            r7_tag;

    always_comb begin
        a2_prod = (TH_W+T_W)'(r6_theta) * (TH_W+T_W)'(r6_tag.t[T_W-1:0])
                + (TH_W+T_W)'(1 << 15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_theta <= r6_theta;
            r7_a2    <= a2_prod[TH_W+15:16];
            r7_tag   <= r6_tag;
        end
    end

    // ---------------- S8: a1 and quadrant fold ----------------
    logic [TH_W-1:0]      a1_raw;
    logic [TH_W-1:0]      a1_red;
    logic [TH_W-1:0]      a2_red;
    logic                 r8_v;
    logic signed [AW-1:0] r8_z1;
    logic signed [AW-1:0] r8_z2;
    t_rot_tag             r8_rtag;
    logic                 r8_dg;

    always_comb begin
        a1_raw = r7_theta - r7_a2;
        a1_red = (a1_raw > HALF_A) ? (PI_A - a1_raw) : a1_raw;
        a2_red = (r7_a2 > HALF_A) ? (PI_A - r7_a2) : r7_a2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_z1      <= signed'(AW'(a1_red));
            r8_z2      <= signed'(AW'(a2_red));
            r8_rtag.lt <= r7_tag.lt;
            r8_rtag.gt <= r7_tag.gt;
            r8_rtag.s  <= r7_tag.s;
            r8_dg      <= r7_tag.dg;
        end
    end

    // ---------------- sines by CORDIC rotation ----------------
    logic                   ra_v;
    logic                   rb_v;
    logic signed [CD_W-1:0] ra_y;
    logic signed [CD_W-1:0] rb_y;
    t_rot_tag               ra_tag;
    logic                   rb_dg;

    qslerp_cordic #(
        .VECTORING (1'b0),
        .STEPS     (CORDIC_STEPS),
        .AFB       (AFB),
        .DW        (CD_W),
        .AW        (AW),
        .TAG_W     ($bits(t_rot_tag))
    ) u_rot_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_x     (GAIN_C),
        .i_y     ('0),
        .i_z     (r8_z1),
        .i_tag   (r8_rtag),
        .o_valid (ra_v),
        .o_x     (),
        .o_y     (ra_y),
        .o_z     (),
        .o_tag   (ra_tag)
    );

    qslerp_cordic #(
        .VECTORING (1'b0),
        .STEPS     (CORDIC_STEPS),
        .AFB       (AFB),
        .DW        (CD_W),
        .AW        (AW),
        .TAG_W     (1)
    ) u_rot_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_x     (GAIN_C),
        .i_y     ('0),
        .i_z     (r8_z2),
        .i_tag   (r8_dg),
        .o_valid (rb_v),
        .o_x     (),
        .o_y     (rb_y),
        .o_z     (),
        .o_tag   (rb_dg)
    );

    // ---------------- weights k = sin(a) / sin(theta) ----------------
    t_div_tag             da_tin;
    t_div_tag             da_tag;
    logic                 da_v;
    logic                 db_v;
    logic signed [KW-1:0] k1;
    logic signed [KW-1:0] k2;
    logic                 db_dg;

    assign da_tin.lt = ra_tag.lt;
    assign da_tin.gt = ra_tag.gt;

    qslerp_div #(
        .NW    (CD_W),
        .SW    (S_W),
        .QW    (DIV_QW),
        .FRAC  (FRAC_Q30),
        .TAG_W ($bits(t_div_tag))
    ) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ra_v & rb_v),
        .i_num   (ra_y),
        .i_den   (ra_tag.s),
        .i_tag   (da_tin),
        .o_valid (da_v),
        .o_quo   (k1),
        .o_tag   (da_tag)
    );

    qslerp_div #(
        .NW    (CD_W),
        .SW    (S_W),
        .QW    (DIV_QW),
        .FRAC  (FRAC_Q30),
        .TAG_W (1)
    ) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ra_v & rb_v),
        .i_num   (rb_y),
        .i_den   (ra_tag.s),
        .i_tag   (rb_dg),
        .o_valid (db_v),
        .o_quo   (k2),
        .o_tag   (db_dg)
    );

    // ---------------- S9: weighted components ----------------
    logic                  r9_v;
    logic signed [P_W-1:0] r9_p1 [4];
    logic signed [P_W-1:0] r9_p2 [4];
    logic                  r9_lt;
    logic                  r9_gt;
    logic                  r9_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= da_v & db_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r9_p1[j] <= P_W'(q1[j]) * P_W'(k1);
                r9_p2[j] <= P_W'(q2[j]) * P_W'(k2);
            end
            r9_lt <= da_tag.lt;
            r9_gt <= da_tag.gt;
            r9_dg <= db_dg;
        end
    end

    // ---------------- output register ----------------
    logic signed [AC_W-1:0] acc  [4];
    logic signed [AC_W-1:0] rnd  [4];
    logic signed [Q_W-1:0]  sat  [4];
    logic signed [Q_W-1:0]  n_q  [4];
    logic                   n_dg;
    logic signed [Q_W-1:0]  r_out_q [4];
    logic                   r_out_dg;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            acc[j] = AC_W'(r9_p1[j]) + AC_W'(r9_p2[j]) + AC_W'(64'sd1 << 29);
            rnd[j] = acc[j] >>> FRAC_Q30;
            if (rnd[j] > AC_W'(32767)) begin
                sat[j] = 16'sh7FFF;
            end else if (rnd[j] < -AC_W'(32768)) begin
                sat[j] = -16'sh8000;
            end else begin
                sat[j] = rnd[j][Q_W-1:0];
            end
        end
        n_dg = 1'b0;
        priority if (r9_lt) begin
            for (int j = 0; j < 4; j++) n_q[j] = q1[j];
        end else if (r9_gt) begin
            for (int j = 0; j < 4; j++) n_q[j] = q2[j];
        end else if (r9_dg) begin
            for (int j = 0; j < 4; j++) n_q[j] = q1[j];
            n_dg = 1'b1;
        end else begin
            for (int j = 0; j < 4; j++) n_q[j] = sat[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r_out_q[j] <= n_q[j];
            end
            r_out_dg <= n_dg;
        end
    end

    assign o_rsp.valid      = r_out_v;
    assign o_rsp.out_x      = r_out_q[0];
    assign o_rsp.out_y      = r_out_q[1];
    assign o_rsp.out_z      = r_out_q[2];
    assign o_rsp.out_w      = r_out_q[3];
    assign o_rsp.degenerate = r_out_dg;

endmodule

// ===== sv/qslerp_chk.sv =====
// ----------------------------------------------------------------------------
// qslerp_chk
// Port-level checks for quaternion_slerp, bound to the top level.
// ----------------------------------------------------------------------------
module qslerp_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [4*qslerp_pkg::Q_W:0]    i_out_data,
    input logic                          i_psel,
    input logic                          i_penable,
    input logic                          i_pwrite,
    input logic [qslerp_pkg::ADDR_W-1:0] i_paddr,
    input logic [qslerp_pkg::DATA_W-1:0] i_pwdata,
    input logic [qslerp_pkg::DATA_W-1:0] i_prdata,
    input logic                          i_pready
);
    import qslerp_pkg::*;

    logic wr;
    assign wr = i_psel & i_penable & i_pwrite & i_pready;

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("pready low");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output transaction changed");

    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> i_in_valid)
        else $error("stalled input transaction dropped");

    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(wr) && i_paddr == $past(i_paddr)
        |-> i_prdata[Q_W-1:0] == $past(i_pwdata[Q_W-1:0]))
        else $error("register readback mismatch");

endmodule

bind quaternion_slerp qslerp_chk u_qslerp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  ({o_rsp.out_x, o_rsp.out_y, o_rsp.out_z, o_rsp.out_w, o_rsp.degenerate}),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata),
    .i_pready    (pready)
);

// ===== tb/quaternion_slerp_test.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp_test
// Self-checking bench for the fixed-point quaternion slerp block. Quaternion
// pairs are loaded over APB while the pipe is empty, and blend values are then
// streamed in bursts against a stalling receiver. Each result is checked field
// by field against a typed row or the in-bench slerp model. Directed rows
// cover the blend extremes, the out-of-range blends and the degenerate
// (equal/opposite) pairs. Random phases follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_slerp_test;
    import qslerp_pkg::*;

    localparam int RUN_LIMIT = 600000;
    localparam int DRAIN_CYC = 130;

    typedef logic signed [Q_W-1:0] t_comp;

    typedef struct {
        t_comp x, y, z, w;
        logic  degen;
    } t_slerp_res;

    typedef struct {
        int                        pair;
        logic signed [BLEND_W-1:0] blend;
        bit                        typed;
        t_slerp_res                res;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    qslerp_in_if  req ();
    qslerp_out_if rsp ();

    t_comp      quat_reg [8];
    t_slerp_res slerp_q [$];
    int         mismatches = 0;
    int         cycles = 0;
    int         holdoff_reqs = 0;
    int         holdoff_seen = 0;
    int         holdoff_left = 0;
    int         burst_left = 0;
    bit         src_on = 1'b0;

    quaternion_slerp u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        req.valid = 1'b0;
        req.blend = '0;
        rsp.ready = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------- fixed-point slerp model ----------------
    function automatic longint angle_of(longint unsigned q60);
        return longint'((q60 + (64'd1 << (59 - ANGLE_FRAC_BITS_DEF))) >>
                        (60 - ANGLE_FRAC_BITS_DEF));
    endfunction

    function automatic longint arc_step(int i);
        longint unsigned sum;
        longint unsigned term;
        int              k;
        sum = 0;
        if (i == 0) return angle_of(PI_Q60 >> 2);
        for (k = 0; i * (2 * k + 1) <= 60; k++) begin
            term = (64'd1 << (60 - i * (2 * k + 1))) / longint'(2 * k + 1);
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        return angle_of(sum);
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint sine_of(longint a, longint pi_a, longint half_a);
        longint sx, sy, sz, nx, ny, st;
        sx = longint'(GAIN_Q30);
        sy = 0;
        if (a > half_a) a = pi_a - a;
        sz = a;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            st = arc_step(i);
            if (sz >= 0) begin
                nx = sx - (sy >>> i); ny = sy + (sx >>> i); sz = sz - st;
            end else begin
                nx = sx + (sy >>> i); ny = sy - (sx >>> i); sz = sz + st;
            end
            sx = nx;
            sy = ny;
        end
        return sy;
    endfunction

    function automatic longint arc_weight(longint sn, longint s);
        longint mag, q;
        mag = (sn < 0) ? -sn : sn;
        q = (mag <<< 30) / s;
        return (sn < 0) ? -q : q;
    endfunction

    function automatic t_comp clip16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return t_comp'(v);
    endfunction

    function automatic t_slerp_res slerp_of(logic signed [BLEND_W-1:0] blend);
        t_slerp_res r;
        longint     t, c, mc, s, pi_a, half_a, vx, vy, vz, nx, ny, st;
        longint     theta, a1, a2, k1, k2, acc;
        longint     q1 [4];
        longint     q2 [4];
        longint     o [4];
        t = longint'(blend);
        for (int j = 0; j < 4; j++) begin
            q1[j] = longint'(quat_reg[j]);
            q2[j] = longint'(quat_reg[4 + j]);
        end
        r.degen = 1'b0;
        if (t < 0) begin
            o = q1;
        end else if (t > BLEND_ONE) begin
            o = q2;
        end else begin
            c = 0;
            for (int j = 0; j < 4; j++) c = c + q1[j] * q2[j];
            if (c > ONE_Q30) c = ONE_Q30;
            if (c < -ONE_Q30) c = -ONE_Q30;
            mc = (c < 0) ? -c : c;
            s = root_floor((64'd1 << 60) - longint'(mc * mc));
            if (s < DEGEN_LIMIT) begin
                r.degen = 1'b1;
                o = q1;
            end else begin
                pi_a = angle_of(PI_Q60);
                half_a = angle_of(PI_Q60 >> 1);
                vx = mc; vy = s; vz = 0;
                for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
                    st = arc_step(i);
                    if (vy >= 0) begin
                        nx = vx + (vy >>> i); ny = vy - (vx >>> i); vz = vz + st;
                    end else begin
                        nx = vx - (vy >>> i); ny = vy + (vx >>> i); vz = vz - st;
                    end
                    vx = nx;
                    vy = ny;
                end
                theta = (c < 0) ? pi_a - vz : vz;
                if (theta < 0) theta = 0;
                if (theta > pi_a) theta = pi_a;
                a2 = (theta * t + 32768) >>> 16;
                a1 = theta - a2;
                k1 = arc_weight(sine_of(a1, pi_a, half_a), s);
                k2 = arc_weight(sine_of(a2, pi_a, half_a), s);
                for (int j = 0; j < 4; j++) begin
                    acc = q1[j] * k1 + q2[j] * k2;
                    o[j] = (acc + (longint'(1) <<< 29)) >>> 30;
                end
            end
        end
        r.x = clip16(o[0]);
        r.y = clip16(o[1]);
        r.z = clip16(o[2]);
        r.w = clip16(o[3]);
        return r;
    endfunction

    // ---------------- receiver and checker ----------------
    always @(negedge i_clk) begin
        if (holdoff_reqs != holdoff_seen) begin
            holdoff_seen = holdoff_reqs;
            holdoff_left = 400;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            rsp.ready <= 1'b0;
        end else begin
            case ((cycles / 97) % 3)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= ($urandom_range(0, 1) == 1);
                default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_slerp_res want;
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("quaternion_slerp verification failed");
            $finish;
        end
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (slerp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycles);
            end else begin
                want = slerp_q.pop_front();
                if (rsp.out_x !== want.x || rsp.out_y !== want.y || rsp.out_z !== want.z ||
                    rsp.out_w !== want.w || rsp.degenerate !== want.degen) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d d%0b got %0d %0d %0d %0d d%0b",
                                 want.x, want.y, want.z, want.w, want.degen,
                                 rsp.out_x, rsp.out_y, rsp.out_z, rsp.out_w, rsp.degenerate);
                end
            end
        end
    end

    // ---------------- sender ----------------
    task automatic send_blend(logic signed [BLEND_W-1:0] b, bit typed, t_slerp_res tr);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && src_on) begin
                req.valid <= 1'b0;
                src_on = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req.valid <= 1'b1;
        req.blend <= b;
        src_on = 1'b1;
        do @(posedge i_clk); while (!req.ready);
        slerp_q.push_back(typed ? tr : slerp_of(b));
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        req.valid <= 1'b0;
        src_on = 1'b0;
        burst_left = 0;
    endtask

    task automatic drain();
        go_idle();
        wait (slerp_q.size() == 0);
    endtask

    task automatic reg_write(t_cfg_idx idx, t_comp v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {{(DATA_W - Q_W){v[Q_W-1]}}, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        quat_reg[idx] = v;
    endtask

    task automatic load_pair(t_comp q [8]);
        drain();
        for (int j = 0; j < 8; j++) reg_write(t_cfg_idx'(j), q[j]);
    endtask

    function automatic void unit_quat(output t_comp q [4]);
        real v [4];
        real n;
        n = 0.0;
        for (int j = 0; j < 4; j++) begin
            v[j] = real'(int'($urandom_range(0, 65535)) - 32768);
            n = n + v[j] * v[j];
        end
        if (n < 1.0) begin
            v[3] = 1.0;
            n = 1.0;
        end
        n = $sqrt(n);
        for (int j = 0; j < 4; j++) q[j] = t_comp'($rtoi(v[j] / n * 32767.0));
    endfunction

    function automatic void random_pair(output t_comp q [8]);
        t_comp a [4];
        t_comp b [4];
        int    mode;
        mode = $urandom_range(0, 9);
        unit_quat(a);
        unit_quat(b);
        for (int j = 0; j < 4; j++) begin
            case (mode)
                0: b[j] = a[j] + t_comp'(int'($urandom_range(0, 8)) - 4);
                1: b[j] = -a[j] + t_comp'(int'($urandom_range(0, 400)) - 200);
                2: begin
                    a[j] = t_comp'($urandom);
                    b[j] = t_comp'($urandom);
                end
                default: ;
            endcase
            q[j] = a[j];
            q[4 + j] = b[j];
        end
    endfunction

    function automatic logic signed [BLEND_W-1:0] random_blend();
        case ($urandom_range(0, 19))
            0: return -$urandom_range(1, 131072);
            1: return $urandom_range(65537, 131071);
            2: return $urandom_range(0, 1) ? 18'sd0 : 18'sd65536;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    t_comp q_reset [8] = '{16'sd0, 16'sd0, 16'sd0, 16'sd32767,
                           16'sd0, 16'sd0, 16'sd0, 16'sd32767};
    t_comp q_pairs [5][8] = '{
        '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd32767},
        '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
          16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384},
        '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
          -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384},
        '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
          16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768},
        '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0}
    };

    t_dir_row dir_rows [] = '{
        '{0, -18'sd131072, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0}},
        '{0, -18'sd1,      1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0}},
        '{0, 18'sd0,       1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{0, 18'sd1,       1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{0, 18'sd32768,   1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{0, 18'sd65535,   1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{0, 18'sd65536,   1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{0, 18'sd65537,   1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0}},
        '{0, 18'sd131071,  1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0}},
        '{1, 18'sd0,     1'b1, '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b1}},
        '{1, 18'sd32768, 1'b1, '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b1}},
        '{1, 18'sd65536, 1'b1, '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b1}},
        '{2, 18'sd32768, 1'b1, '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b1}},
        '{2, 18'sd131071, 1'b1,
          '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 1'b0}},
        '{3, 18'sd21845, 1'b1, '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b1}},
        '{3, -18'sd5,    1'b1, '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0}},
        '{4, 18'sd0,     1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{4, 18'sd16384, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{4, 18'sd43690, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{4, 18'sd65536, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}}
    };

    initial begin
        t_comp pair [8];
        int    cur_pair;
        quat_reg = q_reset;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cur_pair = 0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].pair != cur_pair) begin
                cur_pair = dir_rows[r].pair;
                load_pair(q_pairs[cur_pair]);
            end
            send_blend(dir_rows[r].blend, dir_rows[r].typed, dir_rows[r].res);
        end

        for (int ph = 0; ph < 8; ph++) begin
            random_pair(pair);
            load_pair(pair);
            for (int n = 0; n < 92; n++) begin
                if (ph == 2 && n == 10) holdoff_reqs++;
                if (ph == 5 && n == 46) drain();
                send_blend(random_blend(), 1'b0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0});
            end
        end

        drain();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0 && slerp_q.size() == 0) begin
            $display("quaternion_slerp verification clean");
        end else begin
            $display("quaternion_slerp verification failed");
        end
        $finish;
    end

endmodule
